FILE: sv/pee_pkg.sv
// package for the prefix expression evaluator: character codes, flag layout
// and the alu op codes and command struct shared between the modules
// no dependencies
`default_nettype none
package pee_pkg;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChMul   = 8'h2a;
  localparam logic [7:0] ChDiv   = 8'h2f;
  localparam logic [7:0] ChPoint = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic saturated;
    logic stack_underflow;
    logic stack_overflow;
    logic div_by_zero;
  } flags_t;

  // command from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_cmd_t;

endpackage
`default_nettype wire

FILE: sv/pee_alu.sv
// shared multicycle arithmetic unit: add, subtract, multiply, divide in q format
// one shift-add or restoring-subtract step per cycle; depends on pee_pkg
`default_nettype none
module pee_alu import pee_pkg::*; #(
  parameter int W = 48,
  parameter int F = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire alu_cmd_t     cmd_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              done_o,
  output logic [W-1:0]      res_o,
  output logic              sat_o,
  output logic              dz_o
);

  localparam int CW = $clog2(W + F + 2);
  localparam int PW = 2 * W;
  localparam logic [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};

  logic          busy_q, busy_d;
  op_e           op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  ma_q, ma_d, mb_q, mb_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [W:0]    rem_q, rem_d;
  logic          neg_q, neg_d;
  logic          done_q, done_d;
  logic [W-1:0]  res_q, res_d;
  logic          sat_q, sat_d, dz_q, dz_d;

  logic [W-1:0] mag_a, mag_b;
  logic [W:0]   sum_ext;
  logic [W:0]   rem_sh;
  logic [PW-1:0] rnd;
  logic [W:0]    mag_r;
  logic          big;

  assign mag_a = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + 1'b1) : b_i;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    sat_d  = 1'b0;
    dz_d   = 1'b0;
    sum_ext = '0;
    rem_sh  = '0;
    rnd     = '0;
    mag_r   = '0;
    big     = 1'b0;
    if (cmd_i.start) begin
      op_d  = cmd_i.op;
      ma_d  = mag_a;
      mb_d  = mag_b;
      neg_d = a_i[W-1] ^ b_i[W-1];
      acc_d = '0;
      rem_d = '0;
      cnt_d = '0;
      if (cmd_i.op == OP_ADD || cmd_i.op == OP_SUB) begin
        sum_ext = (cmd_i.op == OP_ADD) ? ({a_i[W-1], a_i} + {b_i[W-1], b_i})
                                       : ({a_i[W-1], a_i} - {b_i[W-1], b_i});
        done_d = 1'b1;
        if (sum_ext[W] != sum_ext[W-1]) begin
          sat_d = 1'b1;
          res_d = sum_ext[W] ? VMin : VMax;
        end else begin
          res_d = sum_ext[W-1:0];
        end
      end else if (cmd_i.op == OP_DIV && mag_b == '0) begin
        done_d = 1'b1;
        dz_d   = 1'b1;
        res_d  = a_i[W-1] ? VMin : VMax;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        // one multiplier bit per cycle, lsb first
        if (cnt_q == CW'(W)) begin
          rnd = acc_q + PW'(1) << (F - 1);
          rnd = (acc_q + (PW'(1) << (F - 1))) >> F;
          big = |rnd[PW-1:W];
          mag_r = {1'b0, rnd[W-1:0]};
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          if (mb_q[cnt_q[$clog2(W)-1:0]]) begin
            acc_d = acc_q + (PW'(ma_q) << cnt_q);
          end
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        // restoring division, W + F quotient bits, msb first
        if (cnt_q == CW'(W + F)) begin
          big = |acc_q[PW-1:W];
          mag_r = {1'b0, acc_q[W-1:0]};
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          if (cnt_q < CW'(W)) begin
            rem_sh = {rem_q[W-1:0], ma_q[W-1 - cnt_q[$clog2(W)-1:0]]};
          end else begin
            rem_sh = {rem_q[W-1:0], 1'b0};
          end
          if (rem_sh >= {1'b0, mb_q}) begin
            rem_d = rem_sh - {1'b0, mb_q};
            acc_d = {acc_q[PW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            acc_d = {acc_q[PW-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      if (done_d) begin
        if (neg_q) begin
          if (big || mag_r > {1'b0, VMin}) begin
            sat_d = 1'b1;
            res_d = VMin;
          end else begin
            res_d = ~mag_r[W-1:0] + 1'b1;
          end
        end else begin
          if (big || mag_r > {1'b0, VMax}) begin
            sat_d = 1'b1;
            res_d = VMax;
          end else begin
            res_d = mag_r[W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sat_q  <= sat_d;
      dz_q   <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cnt_q <= cnt_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign dz_o   = dz_q;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_i.start) else $error("alu started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("alu done while busy");
  a_dz_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dz_q |-> done_q) else $error("divide flag without done");
`endif

endmodule
`default_nettype wire

FILE: sv/prefix_expression_evaluator_top.sv
// prefix expression evaluator: a separator or a digit after the point is taken in the
// character state, a digit before the point adds a divide by ten step; an operator pops
// both operands off the stack and runs the shared alu, which works through the multiplier
// bits for multiply and the quotient bits for divide.
// a last item adds the final push and top read, and waits while the previous
// result is not yet taken. reset (rst_ni low, async) clears the sequencer, count, number
// builder and flags.
`default_nettype none
module prefix_expression_evaluator_top import pee_pkg::*; #(
  parameter int STACK_DEPTH = 128,
  parameter int FRAC_BITS   = 16,
  parameter int INT_BITS    = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // ch
  input  wire logic        s_axis_tlast_i,  // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o   // value[47:0], div_by_zero, stack_overflow,
                                            // stack_underflow, saturated, entries_left[7:0]
);

  localparam int W  = INT_BITS + FRAC_BITS;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int IW = INT_BITS + 4;
  localparam logic [IW-1:0] IMax = IW'((64'd1 << (INT_BITS - 1)) - 64'd1);
  localparam logic [IW-1:0] WCap = IW'(64'd1 << (INT_BITS - 1));
  localparam int FW = FRAC_BITS + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHAR  = 4'd1;
  localparam logic [3:0] S_POPL  = 4'd2;
  localparam logic [3:0] S_POPR  = 4'd3;
  localparam logic [3:0] S_GETR  = 4'd4;
  localparam logic [3:0] S_ALU   = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_TOP   = 4'd8;
  localparam logic [3:0] S_TOPRD = 4'd9;
  localparam logic [3:0] S_DIVF  = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [7:0]      ch_q;
  logic            last_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [IW-1:0]   acc_q, acc_d, wt_q, wt_d;
  logic [FW-1:0]   frac_q, frac_d;
  logic            pt_q, pt_d, innum_q, innum_d;
  flags_t          flg_q, flg_d;
  logic [W-1:0]    l_q, l_d, r_q, r_d;
  logic            lz_q, lz_d, rz_q, rz_d;
  logic [W-1:0]    mem [STACK_DEPTH];
  logic [W-1:0]    rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [W-1:0]    wr_data;
  logic [63:0]     out_q, out_d;
  logic            ov_q, ov_d;
  alu_cmd_t        cmd;
  logic            alu_done, alu_sat, alu_dz;
  logic [W-1:0]    alu_res;
  logic            is_digit;
  logic [3:0]      dig;
  logic [IW+3:0]   prod;
  logic [FW+4:0]   fsum;
  logic [W:0]      numv;
  logic            do_push;
  logic [W-1:0]    push_val;

  assign is_digit = (ch_q >= ChZero) && (ch_q <= ChNine);
  assign dig = 4'(ch_q - ChZero);

  pee_alu #(.W(W), .F(FRAC_BITS)) u_alu (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(l_q), .b_i(r_q),
    .done_o(alu_done), .res_o(alu_res), .sat_o(alu_sat), .dz_o(alu_dz)
  );

  always_comb begin
    numv = {1'b0, acc_q[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
           + (pt_q ? (W+1)'(frac_q) : '0);
    if ((|acc_q[IW-1:INT_BITS-1]) || numv[W] || numv[W-1]) begin
      numv = {2'b00, {(W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    wt_d    = wt_q;
    frac_d  = frac_q;
    pt_d    = pt_q;
    innum_d = innum_q;
    flg_d   = flg_q;
    l_d = l_q; r_d = r_q; lz_d = lz_q; rz_d = rz_q;
    out_d = out_q;
    ov_d  = ov_q;
    cmd   = '0;
    rd_addr = AW'(cnt_q - 1'b1);
    do_push = 1'b0;
    push_val = alu_res;
    prod = '0;
    fsum = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) state_d = S_CHAR;
      end
      S_CHAR: begin
        if (is_digit) begin
          prod = (IW+4)'(acc_q) + (IW+4)'(wt_q) * (IW+4)'(dig);
          if (prod > (IW+4)'(IMax)) begin
            acc_d = IMax;
            flg_d.saturated = 1'b1;
          end else begin
            acc_d = prod[IW-1:0];
          end
          prod = (IW+4)'(wt_q) * (IW+4)'(4'd10);
          wt_d = (prod > (IW+4)'(WCap)) ? WCap : prod[IW-1:0];
          innum_d = 1'b1;
          if (!pt_q) begin
            fsum = (FW+5)'(frac_q) + ((FW+5)'(dig) << FRAC_BITS) + (FW+5)'(5);
            state_d = S_DIVF;
          end else begin
            state_d = last_q ? S_FIN : S_IDLE;
          end
        end else if (ch_q == ChPoint) begin
          if (!pt_q) begin
            pt_d = 1'b1;
            acc_d = '0;
            wt_d = IW'(1);
          end
          innum_d = 1'b1;
          state_d = last_q ? S_FIN : S_IDLE;
        end else begin
          if (innum_q) begin
            do_push = 1'b1;
            push_val = numv[W-1:0];
            if (numv[W-1:0] == {1'b0, {(W-1){1'b1}}} && !((|acc_q[IW-1:INT_BITS-1]) == 1'b0
                && {1'b0, acc_q[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
                   + (pt_q ? (W+1)'(frac_q) : '0) <= (W+1)'({1'b0, {(W-1){1'b1}}})))
              flg_d.saturated = 1'b1;
            acc_d = '0; wt_d = IW'(1); frac_d = '0; pt_d = 1'b0; innum_d = 1'b0;
          end
          if (ch_q == ChPlus || ch_q == ChMinus || ch_q == ChMul || ch_q == ChDiv)
            state_d = S_POPL;
          else
            state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_DIVF: begin
        // fraction_part / 10 with a tiny quotient range: (x * 205) >> 11 is exact for x < 1029,
        // so use a reciprocal wide enough for any FRAC_BITS
        fsum = (FW+5)'(frac_q) + ((FW+5)'(dig) << FRAC_BITS) + (FW+5)'(5);
        frac_d = FW'(((FW+5+32)'(fsum) * (FW+5+32)'(32'hCCCCCCCD)) >> 35);
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_POPL: begin
        lz_d = (cnt_q == '0);
        if (cnt_q == '0) flg_d.stack_underflow = 1'b1;
        else cnt_d = cnt_q - 1'b1;
        state_d = S_POPR;
      end
      S_POPR: begin
        l_d = lz_q ? '0 : rd_q;
        rz_d = (cnt_q == '0);
        if (cnt_q == '0) flg_d.stack_underflow = 1'b1;
        else cnt_d = cnt_q - 1'b1;
        state_d = S_GETR;
      end
      S_GETR: begin
        r_d = rz_q ? '0 : rd_q;
        state_d = S_ALU;
      end
      S_ALU: begin
        cmd.start = 1'b1;
        case (ch_q)
          ChPlus:  cmd.op = OP_ADD;
          ChMinus: cmd.op = OP_SUB;
          ChMul:   cmd.op = OP_MUL;
          default: cmd.op = OP_DIV;
        endcase
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (alu_done) begin
          do_push = 1'b1;
          if (alu_sat) flg_d.saturated = 1'b1;
          if (alu_dz) flg_d.div_by_zero = 1'b1;
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (innum_q) begin
          do_push = 1'b1;
          push_val = numv[W-1:0];
          if ((|acc_q[IW-1:INT_BITS-1]) || ({1'b0, acc_q[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
              + (pt_q ? (W+1)'(frac_q) : '0) > (W+1)'({1'b0, {(W-1){1'b1}}})))
            flg_d.saturated = 1'b1;
        end
        state_d = S_TOPRD;
      end
      S_TOPRD: begin
        // top address settles after the final push
        state_d = S_TOP;
      end
      S_TOP: begin
        if (!ov_q || m_axis_tready_i) begin
          state_d = S_IDLE;
          out_d = '0;
          out_d[47:0] = (cnt_q == '0) ? 48'd0 : 48'(signed'(rd_q));
          out_d[48] = flg_q.div_by_zero;
          out_d[49] = flg_q.stack_overflow;
          out_d[50] = flg_q.stack_underflow;
          out_d[51] = flg_q.saturated;
          out_d[59:52] = 8'(cnt_q);
          ov_d = 1'b1;
          cnt_d = '0; acc_d = '0; wt_d = IW'(1); frac_d = '0;
          pt_d = 1'b0; innum_d = 1'b0; flg_d = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (do_push) begin
      if (cnt_q >= CNTW'(STACK_DEPTH)) flg_d.stack_overflow = 1'b1;
      else cnt_d = cnt_q + 1'b1;
    end
    if (ov_q && m_axis_tready_i && state_q != S_TOP) ov_d = 1'b0;
  end

  assign wr_en   = do_push && (cnt_q < CNTW'(STACK_DEPTH));
  assign wr_addr = AW'(cnt_q);
  assign wr_data = push_val;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      wt_q    <= IW'(1);
      frac_q  <= '0;
      pt_q    <= 1'b0;
      innum_q <= 1'b0;
      flg_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      wt_q    <= wt_d;
      frac_q  <= frac_d;
      pt_q    <= pt_d;
      innum_q <= innum_d;
      flg_q   <= flg_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      ch_q   <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    l_q   <= l_d;
    r_q   <= r_d;
    lz_q  <= lz_d;
    rz_q  <= rz_d;
    out_q <= out_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(STACK_DEPTH)) else $error("stack count out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready_i) |=> ov_q) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o) else $error("accept while busy");
`endif

endmodule
`default_nettype wire

FILE: verif/prefix_expression_evaluator_checker.sv
// checker for the prefix expression evaluator: watches both stream channels,
// predicts each expression result and compares it field by field
// depends on pee_pkg for the character codes
module prefix_expression_evaluator_checker import pee_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,
  input  wire logic        s_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [63:0] m_tdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 128;
  localparam int FRAC = 16;
  localparam longint VMAX = (64'sd1 <<< 47) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint unsigned IMAX = (64'd1 << 31) - 1;

  typedef struct {
    logic [47:0] value;
    logic        div_by_zero;
    logic        stack_overflow;
    logic        stack_underflow;
    logic        saturated;
    logic [7:0]  entries_left;
  } eval_result_t;

  eval_result_t expected_results[$];

  longint          opnd[DEPTH];
  int              depth_cnt;
  longint unsigned acc;
  longint unsigned weight;
  longint unsigned frac;
  bit              pt_seen;
  bit              in_num;
  flags_t          err;

  assign pending_o = expected_results.size();

  function automatic void clear_eval();
    depth_cnt = 0;
    acc = 0;
    weight = 1;
    frac = 0;
    pt_seen = 0;
    in_num = 0;
    err = '0;
  endfunction

  function automatic void push_opnd(longint v);
    if (depth_cnt >= DEPTH) begin
      err.stack_overflow = 1;
    end else begin
      opnd[depth_cnt] = v;
      depth_cnt++;
    end
  endfunction

  function automatic longint pop_opnd();
    if (depth_cnt == 0) begin
      err.stack_underflow = 1;
      return 0;
    end
    depth_cnt--;
    return opnd[depth_cnt];
  endfunction

  function automatic logic [127:0] mag_of(longint v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m;
  endfunction

  function automatic longint signed_sat(logic [127:0] m, bit neg);
    if (neg) begin
      if (m > 128'(64'd1 << 47)) begin
        err.saturated = 1;
        return VMIN;
      end
      return -longint'(m[63:0]);
    end
    if (m > 128'(VMAX)) begin
      err.saturated = 1;
      return VMAX;
    end
    return longint'(m[63:0]);
  endfunction

  function automatic longint clamp_sum(longint r);
    if (r > VMAX) begin
      err.saturated = 1;
      return VMAX;
    end
    if (r < VMIN) begin
      err.saturated = 1;
      return VMIN;
    end
    return r;
  endfunction

  function automatic void end_number();
    longint unsigned v;
    if (!in_num) return;
    v = acc << FRAC;
    if (pt_seen) v += frac;
    if (v > longint'(VMAX)) begin
      v = VMAX;
      err.saturated = 1;
    end
    push_opnd(longint'(v));
    acc = 0;
    weight = 1;
    frac = 0;
    pt_seen = 0;
    in_num = 0;
  endfunction

  function automatic void eval_step(logic [7:0] c, logic is_last);
    longint unsigned d, s;
    longint l, r, res;
    logic [127:0] ml, mr;
    bit neg;
    eval_result_t e;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
      s = acc + d * weight;
      if (s > IMAX) begin
        s = IMAX;
        err.saturated = 1;
      end
      acc = s;
      weight = weight * 10;
      if (weight > IMAX + 1) weight = IMAX + 1;
      if (!pt_seen) frac = (frac + (d << FRAC) + 5) / 10;
      in_num = 1;
    end else if (c == ChPoint) begin
      if (!pt_seen) begin
        pt_seen = 1;
        acc = 0;
        weight = 1;
      end
      in_num = 1;
    end else begin
      end_number();
      if (c == ChPlus || c == ChMinus || c == ChMul || c == ChDiv) begin
        l = pop_opnd();
        r = pop_opnd();
        ml = mag_of(l);
        mr = mag_of(r);
        neg = (l < 0) != (r < 0);
        if (c == ChPlus) res = clamp_sum(l + r);
        else if (c == ChMinus) res = clamp_sum(l - r);
        else if (c == ChMul) res = signed_sat((ml * mr + (128'd1 << (FRAC - 1))) >> FRAC, neg);
        else if (mr == 0) begin
          err.div_by_zero = 1;
          res = (l < 0) ? VMIN : VMAX;
        end else res = signed_sat((ml << FRAC) / mr, neg);
        push_opnd(res);
      end
    end
    if (!is_last) return;
    end_number();
    e.value = (depth_cnt > 0) ? opnd[depth_cnt - 1][47:0] : '0;
    e.div_by_zero = err.div_by_zero;
    e.stack_overflow = err.stack_overflow;
    e.stack_underflow = err.stack_underflow;
    e.saturated = err.saturated;
    e.entries_left = 8'(depth_cnt);
    expected_results.push_back(e);
    clear_eval();
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t e;
    if (!rst_ni) begin
      clear_eval();
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", longint'(m_tdata_i), 0);
        end else begin
          e = expected_results.pop_front();
          if (m_tdata_i[47:0] !== e.value)
            report_mismatch("value", longint'(m_tdata_i[47:0]), longint'(e.value));
          if (m_tdata_i[48] !== e.div_by_zero)
            report_mismatch("div_by_zero", m_tdata_i[48], e.div_by_zero);
          if (m_tdata_i[49] !== e.stack_overflow)
            report_mismatch("stack_overflow", m_tdata_i[49], e.stack_overflow);
          if (m_tdata_i[50] !== e.stack_underflow)
            report_mismatch("stack_underflow", m_tdata_i[50], e.stack_underflow);
          if (m_tdata_i[51] !== e.saturated)
            report_mismatch("saturated", m_tdata_i[51], e.saturated);
          if (m_tdata_i[59:52] !== e.entries_left)
            report_mismatch("entries_left", m_tdata_i[59:52], e.entries_left);
        end
      end
      if (s_tvalid_i && s_tready_i) eval_step(s_tdata_i, s_tlast_i);
    end
  end

endmodule

FILE: verif/prefix_expression_evaluator_top_tb.sv
// testbench top for the prefix expression evaluator: clock, reset, character
// stream stimulus with bursts and a stalling receiver, and the verdict
// depends on pee_pkg, prefix_expression_evaluator_top and the checker
module prefix_expression_evaluator_top_tb import pee_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1850;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  int          burst_left = 0;
  int          chars_sent = 0;
  int          rx_cyc = 0;

  always #1 clk_i = ~clk_i;

  prefix_expression_evaluator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // ch
    .s_axis_tlast_i  (s_tlast),   // last
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // value, flags, entries_left
  );

  prefix_expression_evaluator_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: long hold-off window, otherwise rotating stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 0;
      rx_cyc <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc >= 4000 && rx_cyc < 7000) m_tready <= 0;
      else case (rx_cyc[9:8])
        2'd0: m_tready <= 1;
        2'd1: m_tready <= $urandom_range(0, 1);
        2'd2: m_tready <= (rx_cyc[1:0] == 2'd0);
        default: m_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic send_char(logic [7:0] c, logic l);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_tvalid <= 1;
    s_tdata <= c;
    s_tlast <= l;
    do @(posedge clk_i); while (!s_tready);
    chars_sent++;
    burst_left--;
    if (burst_left == 0) s_tvalid <= 0;
  endtask

  // feed order is already right to left; the final byte carries last
  task automatic send_feed(logic [7:0] feed[$]);
    foreach (feed[i]) send_char(feed[i], i == feed.size() - 1);
  endtask

  task automatic send_prefix(string s);
    logic [7:0] feed[$];
    for (int i = s.len() - 1; i >= 0; i--) feed.push_back(s[i]);
    send_feed(feed);
  endtask

  function automatic logic [7:0] pick_op();
    logic [7:0] ops[4] = '{ChPlus, ChMinus, ChMul, ChDiv};
    return ops[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] pick_sep();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'h20;
    do c = 8'($urandom_range(0, 255));
    while ((c >= ChZero && c <= ChNine) || c == ChPoint || c == ChPlus || c == ChMinus ||
           c == ChMul || c == ChDiv);
    return c;
  endfunction

  task automatic add_number(ref logic [7:0] feed[$]);
    int n;
    int pt_at;
    if ($urandom_range(0, 6) == 0) begin
      feed.push_back(ChZero);
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 5);
    pt_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == pt_at) feed.push_back(ChPoint);
      feed.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    if (pt_at == n) feed.push_back(ChPoint);
    if ($urandom_range(0, 15) == 0) feed.push_back(ChPoint);
  endtask

  task automatic send_random_expr();
    logic [7:0] feed[$];
    int nums, depth, kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) feed.push_back(8'($urandom_range(0, 255)));
    end else begin
      nums = (kind == 1) ? $urandom_range(129, 134) : $urandom_range(1, 8);
      depth = 0;
      while (nums > 0 || depth > 1) begin
        if (nums > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
          add_number(feed);
          feed.push_back(pick_sep());
          nums--;
          depth++;
        end else begin
          feed.push_back(pick_op());
          depth--;
        end
      end
      if (kind == 2) feed.push_back(pick_op());
      if (kind == 3 && feed.size() > 2) feed.delete($urandom_range(0, feed.size() - 1));
      if (feed.size() > 1 && feed[feed.size() - 1] == 8'h20 && $urandom_range(0, 1) == 0)
        void'(feed.pop_back());
    end
    send_feed(feed);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_prefix("+ 1 2");
    send_prefix("- 1.5 20");
    send_prefix("* 2.25 4");
    send_prefix("/ 7 3");
    send_prefix("/ 1 0");
    send_prefix("/ - 0 1 0");
    send_prefix("* - 0 3.5 2.3");
    send_prefix("* 99999999999 99999");
    send_prefix("+ 2147483647 2147483647");
    send_prefix("1..5");
    send_prefix("..");
    send_prefix("+");
    send_prefix("- 7");
    send_prefix("x");
    send_prefix("0.00001");
    send_prefix("/ 0 0");
    send_prefix("9.99999999");
    while (chars_sent < ITEM_TARGET) send_random_expr();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
